[hdl/jdls_pkg.sv]
// ----------------------------------------------------------------------------
// jdls_pkg: shared types and constants of the jerk-driven cart-table step
// Register indexes, command codes and coefficient limits.
// ----------------------------------------------------------------------------
`default_nettype none
package jdls_pkg;
   localparam int unsigned PeriodWidth = 24;
   localparam int unsigned CountWidth  = 6;
   localparam int unsigned CoefWidth   = 29;
   localparam logic [28:0] CoefMax     = 29'h1FFF_FFFF;

   typedef enum logic [1:0] {
      REG_CONTROL_PERIOD = 2'd0,
      REG_SAMPLE_PERIOD  = 2'd1,
      REG_HEIGHT_GAIN    = 2'd2,
      REG_INTERP_COUNT   = 2'd3
   } reg_index_type;

   localparam logic CmdLoad = 1'b0;
   localparam logic CmdStep = 1'b1;
endpackage
`default_nettype wire

[hdl/jerk_driven_lipm_step.sv]
// ----------------------------------------------------------------------------
// jerk_driven_lipm_step: jerk-driven cart-table model on two axes
// Loads or steps a triple-integrator state per axis and emits sub-samples
// with their ZMP, using one shared signed multiplier (33x31 by default) for the coefficient, state and ZMP products.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  req_    | in        | req_valid / req_stall, one command per transfer
//  rsp_    | out       | rsp_valid / rsp_stall, one sub-sample per transfer
//  csr_    | in        | csr_write_enable, no wait
//
//  A sub-sample runs the coefficients (time, square, c2, cube product,
//  division by three), multiply-accumulate and rounding for the six state
//  values, the two ZMP products and the emit; the single multiplier, used
//  at most once a cycle, serves them all. A step then adds a coefficient,
//  multiply-accumulate and rounding pass for the state update; req_stall
//  stays high until that pass ends, and after a load until emit is done.
//  Reset is synchronous and clears control state and registers to defaults.
//  A stalled result holds; the sequencer waits in emit until it is taken.
`default_nettype none
module jerk_driven_lipm_step
   import jdls_pkg::*;
#(
   parameter int unsigned MAX_SUBSTEPS = 32,
   parameter int unsigned VALUE_WIDTH  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_cmd,
   input  wire logic signed [VALUE_WIDTH-1:0] req_load_x_pos,
   input  wire logic signed [VALUE_WIDTH-1:0] req_load_x_vel,
   input  wire logic signed [VALUE_WIDTH-1:0] req_load_x_acc,
   input  wire logic signed [VALUE_WIDTH-1:0] req_load_y_pos,
   input  wire logic signed [VALUE_WIDTH-1:0] req_load_y_vel,
   input  wire logic signed [VALUE_WIDTH-1:0] req_load_y_acc,
   input  wire logic signed [VALUE_WIDTH-1:0] req_jerk_x,
   input  wire logic signed [VALUE_WIDTH-1:0] req_jerk_y,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic signed [VALUE_WIDTH-1:0] rsp_out_x_pos,
   output      logic signed [VALUE_WIDTH-1:0] rsp_out_x_vel,
   output      logic signed [VALUE_WIDTH-1:0] rsp_out_x_acc,
   output      logic signed [VALUE_WIDTH-1:0] rsp_out_y_pos,
   output      logic signed [VALUE_WIDTH-1:0] rsp_out_y_vel,
   output      logic signed [VALUE_WIDTH-1:0] rsp_out_y_acc,
   output      logic signed [VALUE_WIDTH-1:0] rsp_zmp_x,
   output      logic signed [VALUE_WIDTH-1:0] rsp_zmp_y,
   output      logic        rsp_last,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_write_data
);
   localparam int unsigned VW  = VALUE_WIDTH;
   localparam int unsigned AW  = VW + 60;          // accumulator width
   localparam int unsigned KW  = $clog2(MAX_SUBSTEPS + 1);
   localparam int unsigned TW  = PeriodWidth + KW;  // k*sample_period
   localparam int unsigned MW  = (VW > 32) ? VW : 32;
   localparam int unsigned MA  = MW + 1;           // signed multiplier operand a
   localparam logic signed [AW-1:0] SatHi = AW'((64'(1) << (VW - 1)) - 64'(1));
   localparam logic signed [AW-1:0] SatLo = -SatHi - AW'(1);
   localparam logic signed [AW-1:0] Half  = AW'(64'(1) << 23);
   // x/3 split as x = hi*2^17 + lo: hi*43690 + (2*hi + lo)/3
   localparam logic [15:0] DivHiWeight = 16'd43690;
   localparam logic [17:0] DivRecip    = 18'd174763;   // (2^19 + 1) / 3

   typedef enum logic [3:0] {
      ST_IDLE, ST_TIME, ST_SQ, ST_C2, ST_C3MUL, ST_DIV, ST_MAC, ST_RND,
      ST_ZMUL, ST_ZRND, ST_EMIT, ST_WAIT
   } state_type;

   // configuration
   logic [23:0]           ctrl_period_ff, sample_period_ff, gain_ff;
   logic [CountWidth-1:0] count_ff;

   state_type             state_ff;
   logic [VW-1:0]         st_ff [6];   // x pos,vel,acc, y pos,vel,acc
   logic [VW-1:0]         res_ff [6];
   logic [VW-1:0]         zmp_ff [2];
   logic signed [VW-1:0]  jx_ff, jy_ff;
   logic [KW-1:0]         k_ff, n_ff;
   logic                  upd_ff;     // final pass: state update
   logic                  load_ff;    // current command is a load
   logic [CoefWidth-1:0]  c_ff [3];
   logic [63:0]           prod_ff;    // coefficient products
   logic [33:0]           rem_ff;     // cubic dividend over 2^24
   logic [3:0]            term_ff;    // MAC term index
   logic [2:0]            out_ff;     // output index 0..5 / zmp axis
   logic signed [AW-1:0]  acc_ff;
   logic                  valid_ff, last_ff;

   // shared multiplier operands
   logic signed [MA-1:0]  mul_a;
   logic signed [30:0]    mul_b;
   logic signed [MA+30:0] mul_p;

   // division by three of the cubic dividend
   logic [18:0]           div_y;
   logic [36:0]           div_r;
   logic [33:0]           div_quot;

   function automatic logic [CoefWidth-1:0] clip(input logic [63:0] v);
      return (v > 64'(CoefMax)) ? CoefMax : v[CoefWidth-1:0];
   endfunction

   function automatic logic signed [AW-1:0] rnd24(input logic signed [AW-1:0] v);
      return (v + Half) >>> 24;   // floor after half add = half up
   endfunction

   function automatic logic [VW-1:0] sat(input logic signed [AW-1:0] v);
      if (v > SatHi) return SatHi[VW-1:0];
      if (v < SatLo) return SatLo[VW-1:0];
      return v[VW-1:0];
   endfunction

   // term table: which state value and coefficient feed output out_ff
   logic signed [VW-1:0]  op_s;
   logic [CoefWidth:0]    op_c;   // coefficient or the 2^24 weight
   logic [3:0]            nterms;
   logic [1:0]            ax_base;
   logic [1:0]            row;
   always_comb begin
      row     = (out_ff >= 3'd3) ? 2'(out_ff - 3'd3) : out_ff[1:0];
      ax_base = (out_ff >= 3'd3) ? 2'd3 : 2'd0;
      nterms  = 4'(4 - row);
      // term t: t < nterms-1 uses state[row+t] with weight (t==0?2^24:c[t-1]);
      // final term uses jerk with c[2-row]
      op_s = '0;
      op_c = '0;
      if (term_ff == nterms - 4'd1) begin
         op_s = (out_ff >= 3'd3) ? jy_ff : jx_ff;
         op_c = {1'b0, c_ff[2'd2 - row]};
      end else begin
         op_s = $signed(st_ff[3'(ax_base) + 3'(row) + 3'(term_ff)]);
         op_c = (term_ff == 4'd0) ? {1'b0, 29'(1 << 24)}
                                  : {1'b0, c_ff[2'(term_ff - 4'd1)]};
      end
   end

   logic [TW-1:0] t_now;
   always_comb begin
      t_now = upd_ff ? TW'(ctrl_period_ff) : TW'(k_ff) * TW'(sample_period_ff);
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQ:    begin mul_a = MA'(c_ff[0]); mul_b = 31'(c_ff[0]); end
         ST_C3MUL: begin mul_a = MA'(c_ff[1]); mul_b = 31'(c_ff[0]); end
         ST_MAC:   begin mul_a = MA'(op_s);    mul_b = 31'(op_c);    end
         ST_ZMUL:  begin
            mul_a = MA'($signed(res_ff[out_ff[0] ? 3'd5 : 3'd2]));
            mul_b = 31'(gain_ff);
         end
         default:  begin mul_a = '0; mul_b = '0; end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      div_y    = 19'({rem_ff[33:17], 1'b0}) + 19'(rem_ff[16:0]);
      div_r    = 37'(div_y) * 37'(DivRecip);
      div_quot = 34'(rem_ff[33:17]) * 34'(DivHiWeight) + 34'(div_r[36:19]);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         valid_ff         <= 1'b0;
         ctrl_period_ff   <= 24'd1677722;
         sample_period_ff <= 24'd83886;
         gain_ff          <= 24'd1392148;
         count_ff         <= 6'd20;
         for (int i = 0; i < 6; i++) st_ff[i] <= '0;
      end else begin
         if (csr_write_enable) begin
            case (reg_index_type'(csr_index))
               REG_CONTROL_PERIOD: ctrl_period_ff   <= csr_write_data;
               REG_SAMPLE_PERIOD:  sample_period_ff <= csr_write_data;
               REG_HEIGHT_GAIN:    gain_ff          <= csr_write_data;
               REG_INTERP_COUNT:   count_ff         <= csr_write_data[CountWidth-1:0];
               default: ;
            endcase
         end
         // raise valid on a new result, drop it once the transfer is taken
         if (state_ff == ST_EMIT && (!valid_ff || !rsp_stall)) valid_ff <= 1'b1;
         else if (valid_ff && !rsp_stall) valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  jx_ff <= req_jerk_x;
                  jy_ff <= req_jerk_y;
                  k_ff  <= KW'(1);
                  upd_ff <= 1'b0;
                  load_ff <= (req_cmd == CmdLoad);
                  if (count_ff == '0) n_ff <= KW'(1);
                  else if (7'(count_ff) > 7'(MAX_SUBSTEPS)) n_ff <= KW'(MAX_SUBSTEPS);
                  else n_ff <= KW'(count_ff);
                  if (req_cmd == CmdLoad) begin
                     st_ff[0] <= req_load_x_pos; st_ff[1] <= req_load_x_vel;
                     st_ff[2] <= req_load_x_acc; st_ff[3] <= req_load_y_pos;
                     st_ff[4] <= req_load_y_vel; st_ff[5] <= req_load_y_acc;
                     res_ff[0] <= req_load_x_pos; res_ff[1] <= req_load_x_vel;
                     res_ff[2] <= req_load_x_acc; res_ff[3] <= req_load_y_pos;
                     res_ff[4] <= req_load_y_vel; res_ff[5] <= req_load_y_acc;
                     last_ff  <= 1'b1;
                     out_ff   <= '0;
                     state_ff <= ST_ZMUL;
                  end else begin
                     state_ff <= ST_TIME;
                  end
               end
            end
            ST_TIME: begin
               c_ff[0]  <= clip(64'(t_now));
               state_ff <= ST_SQ;
            end
            ST_SQ: begin
               prod_ff  <= 64'(mul_p);
               state_ff <= ST_C2;
            end
            ST_C2: begin
               c_ff[1]  <= clip((prod_ff + 64'(1 << 24)) >> 25);
               state_ff <= ST_C3MUL;
            end
            ST_C3MUL: begin
               // dividend for /(3*2^24): take the 2^24 part here, three next
               rem_ff   <= 34'((64'(mul_p) + 64'(3 * (1 << 23))) >> 24);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               c_ff[2]  <= clip(64'(div_quot));
               term_ff  <= '0;
               out_ff   <= '0;
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               acc_ff <= ((term_ff == 4'd0) ? '0 : acc_ff) + AW'(mul_p);
               if (term_ff == nterms - 4'd1) state_ff <= ST_RND;
               else term_ff <= term_ff + 4'd1;
            end
            ST_RND: begin
               res_ff[out_ff] <= sat(rnd24(acc_ff));
               term_ff <= '0;
               if (out_ff == 3'd5) begin
                  out_ff   <= '0;
                  if (upd_ff) begin
                     for (int i = 0; i < 5; i++) st_ff[i] <= res_ff[i];
                     st_ff[5]  <= sat(rnd24(acc_ff));
                     state_ff  <= ST_IDLE;
                  end else begin
                     last_ff  <= (k_ff == n_ff);
                     state_ff <= ST_ZMUL;
                  end
               end else begin
                  out_ff   <= out_ff + 3'd1;
                  state_ff <= ST_MAC;
               end
            end
            ST_ZMUL: begin
               acc_ff   <= AW'(mul_p);
               state_ff <= ST_ZRND;
            end
            ST_ZRND: begin
               zmp_ff[out_ff[0]] <= sat($signed(AW'($signed(res_ff[out_ff[0] ? 3'd3 : 3'd0])))
                                        - rnd24(acc_ff));
               if (out_ff[0]) begin
                  out_ff   <= '0;
                  state_ff <= ST_EMIT;
               end else begin
                  out_ff   <= 3'd1;
                  state_ff <= ST_ZMUL;
               end
            end
            ST_EMIT: begin
               if (!valid_ff || !rsp_stall) begin
                  rsp_out_x_pos <= res_ff[0]; rsp_out_x_vel <= res_ff[1];
                  rsp_out_x_acc <= res_ff[2]; rsp_out_y_pos <= res_ff[3];
                  rsp_out_y_vel <= res_ff[4]; rsp_out_y_acc <= res_ff[5];
                  rsp_zmp_x <= zmp_ff[0]; rsp_zmp_y <= zmp_ff[1];
                  rsp_last  <= last_ff;
                  state_ff  <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               // finish a load, or advance to the next sub-sample or the update
               if (load_ff) begin
                  state_ff <= ST_IDLE;
               end else if (k_ff == n_ff) begin
                  upd_ff   <= 1'b1;
                  state_ff <= ST_TIME;
               end else begin
                  k_ff     <= k_ff + KW'(1);
                  state_ff <= ST_TIME;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

[hdl/jdls_checker.sv]
// ----------------------------------------------------------------------------
// jdls_checker: port-level checks on the cart-table step block
// ----------------------------------------------------------------------------
`default_nettype none
module jdls_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted a second command at once");
   a_last_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_last))
      else $error("last changed while stalled");
endmodule

bind jerk_driven_lipm_step jdls_checker u_jdls_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_last(rsp_last)
);
`default_nettype wire
